### rtl/core/switch_change_event_queue_top_defines.svh
// Assertion macros used by the switch change event queue RTL.
`ifndef SWITCH_CHANGE_EVENT_QUEUE_TOP_DEFINES_SVH
`define SWITCH_CHANGE_EVENT_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SWCHG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define SWCHG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SWCHG_ASSERT(lbl, clk, rstn, prop, msg)
`define SWCHG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/swchg_pkg.sv
// Types, constants and helper functions of the switch change event queue.
package swchg_pkg;

    // Function codes of an input word.
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Register word index of input_mask.
    localparam logic REG_INPUT_MASK = 1'b0;

    localparam int unsigned SCAN_LINES = 8;
    localparam int unsigned PENDING_W  = 2 * SCAN_LINES;
    localparam logic [7:0]  RELEASE_FLAG = 8'h80;

    typedef struct packed {
        logic       func;
        logic [7:0] pins;
    } in_word_t;

    typedef struct packed {
        logic [7:0] event_code;
        logic       event_valid;
        logic       events_waiting;
        logic [4:0] events_added;
        logic       overflow;
    } out_word_t;

    // Queue status from the event store to the sequencer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Index of the lowest set bit; rose lines occupy 0..7, fell lines 8..15.
    function automatic logic [3:0] lowest_index(input logic [PENDING_W-1:0] bits);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = PENDING_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    // Release code for a rose line, press code for a fell line.
    function automatic logic [7:0] make_code(input logic [3:0] idx);
        logic [7:0] line;
        line = {5'b0, idx[2:0]};
        return idx[3] ? line : (RELEASE_FLAG | line);
    endfunction

endpackage

### rtl/core/swchg_queue.sv
// Circular event store with registered read port and full/empty status.
module swchg_queue #(
    parameter int unsigned QUEUE_SHIFT = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_en,
    input  logic [7:0]            push_code,
    input  logic                  pop_en,
    output logic [7:0]            rd_code,
    output swchg_pkg::q_status_t  status
);

    localparam int unsigned DEPTH = 1 << QUEUE_SHIFT;
    localparam logic [QUEUE_SHIFT-1:0] IDX_ONE = QUEUE_SHIFT'(1);

    logic [7:0]             event_mem [DEPTH];
    logic [QUEUE_SHIFT-1:0] wr_idx_reg, wr_idx_next;
    logic [QUEUE_SHIFT-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]             rd_code_reg;

    // Advance indexes on push and pop.
    always_comb begin
        wr_idx_next = push_en ? (wr_idx_reg + IDX_ONE) : wr_idx_reg;
        rd_idx_next = pop_en  ? (rd_idx_reg + IDX_ONE) : rd_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Write port.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            event_mem[wr_idx_reg] <= push_code;
        end
    end

    // Read port, registered on pop.
    always_ff @(posedge aclk) begin
        if (pop_en) begin
            rd_code_reg <= event_mem[rd_idx_reg];
        end
    end

    assign rd_code      = rd_code_reg;
    assign status.empty = (wr_idx_reg == rd_idx_reg);
    assign status.full  = ((wr_idx_reg + IDX_ONE) == rd_idx_reg);

endmodule

### rtl/core/switch_change_event_queue_top.sv
// Switch change event queue: input word decode, scan sequencer, output register.
//
// Input channel (s_valid/s_ready/s_data): each word is a scan (func = 0) that
// samples eight switch lines through input_mask, or a read (func = 1) that pops
// the oldest queued event code. Every word yields exactly one result word on
// the m_valid/m_ready/m_data channel.
// A scan compares the masked sample with the previous one and queues one
// release code (0x80 | line) per rising line, then one press code per falling
// line. The first scan after reset or after an input_mask write only records
// a baseline. Codes that find the queue full are dropped and flag overflow.
// A scan pushes one code per changed line (up to 8) in the SCAN state, since
// the event memory takes one push per cycle. A read passes through RDATA for
// the registered memory read port, or goes straight to FINISH on an empty queue.
// One word is in flight at a time; a new word is taken while the previous
// result still waits in the output register, and a finished result waits
// there as long as m_ready stays low.
// Reset (aresetn low, synchronous) empties the queue, clears the mask and the
// baseline. input_mask is to be written through the APB port only while idle;
// the user is bound by this, the block itself does not enforce it.
`include "switch_change_event_queue_top_defines.svh"

module switch_change_event_queue_top #(
    parameter int unsigned QUEUE_SHIFT = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input word channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  swchg_pkg::in_word_t   s_data,
    // result word channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output swchg_pkg::out_word_t  m_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RDATA  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int unsigned PW = swchg_pkg::PENDING_W;

    logic [1:0]           state_reg, state_next;
    logic [7:0]           mask_reg, mask_next;
    logic [7:0]           prev_reg, prev_next;
    logic                 baseline_reg, baseline_next;
    logic [PW-1:0]        pending_reg, pending_next;
    logic [7:0]           code_reg, code_next;
    logic                 evv_reg, evv_next;
    logic [4:0]           added_reg, added_next;
    logic                 over_reg, over_next;
    logic                 m_valid_reg, m_valid_next;
    swchg_pkg::out_word_t m_data_reg, m_data_next;

    logic                 push_en;
    logic [7:0]           push_code;
    logic                 pop_en;
    logic [7:0]           rd_code;
    swchg_pkg::q_status_t q_status;

    logic                 s_fire;
    logic                 cfg_wr;
    logic [7:0]           sample;
    logic [3:0]           sel_idx;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign sample  = s_data.pins & mask_reg;
    assign sel_idx = swchg_pkg::lowest_index(pending_reg);

    // Register readback and ready.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == swchg_pkg::REG_INPUT_MASK) ? {24'b0, mask_reg} : 32'b0;

    swchg_queue #(
        .QUEUE_SHIFT (QUEUE_SHIFT)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_code (push_code),
        .pop_en    (pop_en),
        .rd_code   (rd_code),
        .status    (q_status)
    );

    // Sequence one word: decode, push changed lines one per cycle, pop, finish.
    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        prev_next     = prev_reg;
        baseline_next = baseline_reg;
        pending_next  = pending_reg;
        code_next     = code_reg;
        evv_next      = evv_reg;
        added_next    = added_reg;
        over_next     = over_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        push_en       = 1'b0;
        push_code     = swchg_pkg::make_code(sel_idx);
        pop_en        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    code_next  = 8'd0;
                    evv_next   = 1'b0;
                    added_next = 5'd0;
                    over_next  = 1'b0;
                    if (s_data.func == swchg_pkg::FUNC_READ) begin
                        if (!q_status.empty) begin
                            pop_en     = 1'b1;
                            state_next = ST_RDATA;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        // record the sample; collect rose lines low, fell lines high
                        prev_next     = sample;
                        baseline_next = 1'b1;
                        pending_next  = baseline_reg ?
                                        {prev_reg & ~sample, sample & ~prev_reg} : '0;
                        state_next    = (baseline_reg && (sample != prev_reg)) ?
                                        ST_SCAN : ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // push the lowest pending code, or drop it when full
                if (!q_status.full) begin
                    push_en    = 1'b1;
                    added_next = added_reg + 5'd1;
                end else begin
                    over_next = 1'b1;
                end
                pending_next = pending_reg & ~(PW'(1) << sel_idx);
                if (pending_next == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDATA: begin
                code_next  = rd_code;
                evv_next   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.event_code     = code_reg;
                    m_data_next.event_valid    = evv_reg;
                    m_data_next.events_waiting = !q_status.empty;
                    m_data_next.events_added   = added_reg;
                    m_data_next.overflow       = over_reg;
                    m_valid_next               = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Mask write restarts the baseline.
        if (cfg_wr && (paddr[2] == swchg_pkg::REG_INPUT_MASK)) begin
            mask_next     = pwdata[7:0];
            baseline_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= 8'd0;
            prev_reg     <= 8'd0;
            baseline_reg <= 1'b0;
            pending_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            prev_reg     <= prev_next;
            baseline_reg <= baseline_next;
            pending_reg  <= pending_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        evv_reg    <= evv_next;
        added_reg  <= added_next;
        over_reg   <= over_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SWCHG_ASSERT(a_no_push_full, aclk, aresetn, !(push_en && q_status.full), "push into full queue")
    `SWCHG_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop_en && q_status.empty), "pop from empty queue")
    `SWCHG_ASSERT(a_read_no_add, aclk, aresetn, !(m_valid && m_data.event_valid && (m_data.events_added != 5'd0 || m_data.overflow)), "read result carries scan fields")
    `SWCHG_ASSERT(a_code_shape, aclk, aresetn, !(m_valid && m_data.event_code[6:3] != 4'd0), "malformed event code")
    `SWCHG_ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

endmodule

### verif/switch_change_event_queue_checker.sv
// Scoreboard for the switch change event queue: mirrors the queue and checks every result word.
`timescale 1ns / 100ps

module switch_change_event_queue_checker #(
    parameter int unsigned QUEUE_SHIFT = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  swchg_pkg::in_word_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  swchg_pkg::out_word_t m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   overflow_scans
);

    localparam logic [2:0] MASK_ADDR = {swchg_pkg::REG_INPUT_MASK, 2'b00};
    localparam int unsigned SLOTS = 1 << QUEUE_SHIFT;

    // Mirror of the block state
    logic [7:0]             line_mask;
    logic [7:0]             last_sample;
    logic                   have_baseline;
    logic [7:0]             code_ring [SLOTS];
    logic [QUEUE_SHIFT-1:0] wr_ptr;
    logic [QUEUE_SHIFT-1:0] rd_ptr;

    swchg_pkg::out_word_t expected_words [$];
    int                   fail_count;
    int                   word_count;
    int                   full_count;

    initial begin
        errors         = 0;
        pending        = 0;
        checked        = 0;
        overflow_scans = 0;
        fail_count     = 0;
        word_count     = 0;
        full_count     = 0;
    end

    // Print one mismatch line and count it
    task automatic report_error(input string msg);
        $display("ERROR @%0t: result %0d: %s", $realtime, word_count, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Work out the result of one input word and advance the mirrored queue
    function automatic swchg_pkg::out_word_t predict_word(input swchg_pkg::in_word_t w);
        swchg_pkg::out_word_t   r;
        logic [7:0]             sample;
        logic [7:0]             rose;
        logic [7:0]             fell;
        logic [7:0]             bits;
        logic [QUEUE_SHIFT-1:0] nxt;
        r = '0;
        if (w.func == swchg_pkg::FUNC_SCAN) begin
            sample = w.pins & line_mask;
            if (have_baseline) begin
                rose = sample & ~last_sample;
                fell = last_sample & ~sample;
                // releases first, then presses, lines in ascending order
                for (int p = 0; p < 2; p++) begin
                    bits = (p == 0) ? rose : fell;
                    for (int ln = 0; ln < swchg_pkg::SCAN_LINES; ln++) begin
                        if (bits[ln]) begin
                            nxt = wr_ptr + 1'b1;
                            if (nxt == rd_ptr) begin
                                // drop the code, queue is full
                                r.overflow = 1'b1;
                            end else begin
                                code_ring[wr_ptr] =
                                    ((p == 0) ? swchg_pkg::RELEASE_FLAG : 8'h00) | 8'(ln);
                                wr_ptr = nxt;
                                r.events_added = r.events_added + 5'd1;
                            end
                        end
                    end
                end
            end
            last_sample   = sample;
            have_baseline = 1'b1;
        end else if (rd_ptr != wr_ptr) begin
            r.event_code  = code_ring[rd_ptr];
            r.event_valid = 1'b1;
            rd_ptr        = rd_ptr + 1'b1;
        end
        r.events_waiting = (rd_ptr != wr_ptr);
        return r;
    endfunction

    always @(posedge aclk) begin
        swchg_pkg::out_word_t want;
        if (!aresetn) begin
            line_mask     = '0;
            last_sample   = '0;
            have_baseline = 1'b0;
            wr_ptr        = '0;
            rd_ptr        = '0;
            expected_words.delete();
        end else begin
            // Track mask writes; any other register index is ignored
            if (psel && penable && pwrite && pready && paddr == MASK_ADDR) begin
                line_mask     = pwdata[7:0];
                have_baseline = 1'b0;
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_word(s_data));
            end
            // Compare each accepted result word with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_error("result word with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    check_field("event_code", m_data.event_code, want.event_code);
                    check_field("event_valid", m_data.event_valid, want.event_valid);
                    check_field("events_waiting", m_data.events_waiting,
                                want.events_waiting);
                    check_field("events_added", m_data.events_added, want.events_added);
                    check_field("overflow", m_data.overflow, want.overflow);
                    if (want.overflow) begin
                        full_count++;
                    end
                end
                word_count++;
            end
        end
        errors         <= fail_count;
        pending        <= expected_words.size();
        checked        <= word_count;
        overflow_scans <= full_count;
    end

endmodule

### verif/switch_change_event_queue_top_tb.sv
// Top testbench for the switch change event queue: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps

module switch_change_event_queue_top_tb;

    localparam logic [2:0] MASK_ADDR  = {swchg_pkg::REG_INPUT_MASK, 2'b00};
    // unused register slot, writes there must have no effect
    localparam logic [2:0] SPARE_ADDR = 3'd4;
    localparam int         SEG_WORDS  = 140;
    localparam int         CYCLE_LIMIT = 800000;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    swchg_pkg::in_word_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    swchg_pkg::out_word_t m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [2:0]           paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int errors;
    int pending;
    int checked;
    int overflow_scans;

    swchg_pkg::in_word_t stim_words [$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  cycles        = 0;
    int                  scan_count    = 0;
    int                  read_count    = 0;
    int                  mask_writes   = 0;
    logic [7:0]          last_pins     = '0;

    switch_change_event_queue_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    switch_change_event_queue_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .errors         (errors),
        .pending        (pending),
        .checked        (checked),
        .overflow_scans (overflow_scans)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Feed input words, hold each one until accepted, insert random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.func == swchg_pkg::FUNC_SCAN) begin
                    scan_count <= scan_count + 1;
                end else begin
                    read_count <= read_count + 1;
                end
            end
            if (!s_valid || s_ready) begin
                if (stim_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= stim_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic queue_scan(input logic [7:0] pins);
        swchg_pkg::in_word_t w;
        w.func    = swchg_pkg::FUNC_SCAN;
        w.pins    = pins;
        last_pins = pins;
        stim_words.push_back(w);
    endtask

    task automatic queue_read();
        swchg_pkg::in_word_t w;
        w.func = swchg_pkg::FUNC_READ;
        w.pins = 8'($urandom);
        stim_words.push_back(w);
    endtask

    // Wait until every word is accepted and answered, then let the block settle
    task automatic drain();
        @(posedge aclk);
        while (stim_words.size() != 0 || s_valid || pending != 0) begin
            @(posedge aclk);
        end
        repeat (24) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (addr == MASK_ADDR) begin
            mask_writes++;
        end
    endtask

    // Bursts of scan-heavy, read-heavy, mixed and noisy traffic
    task automatic queue_random(input int n);
        int         made;
        int         burst;
        int         mode;
        int         scan_pct;
        logic [7:0] p;
        made = 0;
        while (made < n) begin
            burst = $urandom_range(1, 24);
            if (burst > n - made) begin
                burst = n - made;
            end
            mode  = $urandom_range(0, 3);
            case (mode)
                0: begin
                    scan_pct = 85;
                end
                1: begin
                    scan_pct = 15;
                end
                2: begin
                    scan_pct = 50;
                end
                default: begin
                    scan_pct = 60;
                end
            endcase
            repeat (burst) begin
                if ($urandom_range(99) < scan_pct) begin
                    if (mode == 3) begin
                        p = 8'($urandom);
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                p = last_pins ^ (8'd1 << $urandom_range(0, 7));
                            end
                            1: begin
                                p = last_pins ^ 8'($urandom);
                            end
                            2: begin
                                p = ~last_pins;
                            end
                            default: begin
                                p = last_pins;
                            end
                        endcase
                    end
                    queue_scan(p);
                end else begin
                    queue_read();
                end
                made++;
            end
        end
    endtask

    initial begin
        logic [7:0] mask_plan [9];
        mask_plan[0] = 8'hFF;
        mask_plan[1] = 8'h00;
        mask_plan[2] = 8'($urandom);
        mask_plan[3] = 8'h01;
        mask_plan[4] = 8'h80;
        mask_plan[5] = 8'($urandom);
        mask_plan[6] = 8'hFF;
        mask_plan[7] = 8'($urandom);
        mask_plan[8] = 8'h5A;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty read, reset mask, full-swing scans, overflow, drain
        queue_read();
        queue_scan(8'hFF);
        queue_scan(8'h00);
        drain();
        write_reg(MASK_ADDR, 32'h0000_00FF);
        write_reg(SPARE_ADDR, 32'h0000_0000);
        queue_scan(8'h00);
        queue_scan(8'hFF);
        queue_scan(8'h00);
        repeat (16) queue_read();
        queue_scan(8'h5A);
        queue_scan(8'hA5);
        queue_read();
        drain();

        // Three pacing phases, three mask settings each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                write_reg(MASK_ADDR, {24'h0, mask_plan[ph * 3 + seg]});
                queue_random(SEG_WORDS);
                drain();
            end
        end

        repeat (40) @(posedge aclk);
        $display("Covered %0d scan words and %0d read words under %0d mask settings",
                 scan_count, read_count, mask_writes);
        $display("%0d result words checked, %0d scans ran into a full queue",
                 checked, overflow_scans);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/swchg_pkg.sv
rtl/core/swchg_queue.sv
rtl/core/switch_change_event_queue_top.sv
verif/switch_change_event_queue_checker.sv
verif/switch_change_event_queue_top_tb.sv
